>>> rtl/tgr_pkg.sv
package tgr_pkg;

  localparam logic [63:0] IV0 = 64'h0123456789ABCDEF;
  localparam logic [63:0] IV1 = 64'hFEDCBA9876543210;
  localparam logic [63:0] IV2 = 64'hF096A5B4C3B2E187;

  localparam logic [63:0] SCHED_K0 = 64'hA5A5A5A5A5A5A5A5;
  localparam logic [63:0] SCHED_K1 = 64'h0123456789ABCDEF;

  localparam logic [63:0] PAD_WORD = 64'h0000000000000001;
  localparam logic [7:0]  PAD_BYTE = 8'h01;

  localparam logic [7:0][63:0] SEED = {
    64'h6D6168694220696C,
    64'h4520646E61206E6F,
    64'h737265646E412073,
    64'h736F52207962202C,
    64'h6E6F6974636E7546,
    64'h2068736148207765,
    64'h4E20747361462041,
    64'h202D207265676954
  };

  typedef struct packed {
    logic        load;
    logic [63:0] word;
    logic        start;
    logic        clear;
  } tgr_core_ctl_t;

  typedef struct packed {
    logic [7:0]  raddr0;
    logic [7:0]  raddr1;
    logic [3:0]  we;
    logic [7:0]  waddr;
    logic [63:0] wdata;
    logic [7:0]  wmask;
  } tgr_mem_req_t;

endpackage

>>> rtl/tiger192_hash.sv
// Tiger-192 hash of a message streamed as little-endian 64-bit words. After reset the block
// builds its four 256 x 64 S-box memories with the standard generation procedure (an initial
// fill of all 256 entries, then 5120 row steps of eight byte swaps and 1707 compressions); data_ready
// stays low until that finishes. A compression runs 24 rounds, each through the states RA, RB
// and RC of one round unit, plus two key schedules and a feedforward per 8-word block.
// A word is taken at once unless it completes a block, which then holds off the next
// word for the compression. A last word pads the message, runs one or two more blocks, and
// returns the three digest words a, b, c in order on the digest channel, digest_last on c.
module tiger192_hash (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_ready,
  input  logic [63:0] data,
  input  logic [3:0]  byte_count,
  input  logic        last,
  output logic        digest_valid,
  input  logic        digest_ready,
  output logic [63:0] digest_word,
  output logic        digest_last
);
  import tgr_pkg::*;

  typedef enum logic [2:0] {T_BUILD, T_CLR, T_IDLE, T_PAD, T_WAIT, T_OUT} state_t;

  state_t      st;
  logic [2:0]  fill;
  logic [63:0] bits;
  logic        need01;
  logic        lenpushed;
  logic        pad;
  logic [1:0]  oidx;

  tgr_core_ctl_t         gen_ctl, my_ctl, core_ctl;
  tgr_mem_req_t          gen_req;
  logic [3:0][1:0][63:0] sdata;
  logic [3:0][1:0][7:0]  core_addr;
  logic [2:0][63:0]      cv;
  logic                  core_busy, core_done, gen_done;

  logic [3:0]  bcs;
  logic [63:0] w0;

  always_comb begin
    bcs = (byte_count > 4'd8) ? 4'd8 : byte_count;
    for (int l = 0; l < 8; l++) begin
      if (4'(l) < bcs)       w0[l*8 +: 8] = data[l*8 +: 8];
      else if (4'(l) == bcs) w0[l*8 +: 8] = PAD_BYTE;
      else                   w0[l*8 +: 8] = 8'h00;
    end

    my_ctl = '0;
    case (st)
      T_IDLE: begin
        my_ctl.load  = data_valid;
        my_ctl.word  = last ? w0 : data;
        my_ctl.start = data_valid && (fill == 3'd7);
      end
      T_PAD: begin
        my_ctl.load  = 1'b1;
        my_ctl.word  = need01 ? PAD_WORD : ((fill == 3'd7) ? bits : 64'd0);
        my_ctl.start = (fill == 3'd7);
      end
      T_CLR: my_ctl.clear = 1'b1;
      T_OUT: my_ctl.clear = digest_ready && (oidx == 2'd2);
      default: ;
    endcase
    core_ctl = (st == T_BUILD) ? gen_ctl : my_ctl;

    case (oidx)
      2'd0:    digest_word = cv[0];
      2'd1:    digest_word = cv[1];
      default: digest_word = cv[2];
    endcase
  end

  assign data_ready   = (st == T_IDLE);
  assign digest_valid = (st == T_OUT);
  assign digest_last  = (oidx == 2'd2);

  tgr_core u_core (
    .clk   (clk),
    .rst   (rst),
    .ctl   (core_ctl),
    .sdata (sdata),
    .saddr (core_addr),
    .cv    (cv),
    .busy  (core_busy),
    .done  (core_done)
  );

  tgr_sgen u_sgen (
    .clk       (clk),
    .rst       (rst),
    .sdata     (sdata),
    .cv        (cv),
    .core_done (core_done),
    .req       (gen_req),
    .ctl       (gen_ctl),
    .done      (gen_done)
  );

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [1:0][7:0] raddr;
    assign raddr = core_busy ? core_addr[b] : {gen_req.raddr1, gen_req.raddr0};
    tgr_sbox u_sbox (
      .clk   (clk),
      .raddr (raddr),
      .rdata (sdata[b]),
      .we    (gen_req.we[b]),
      .waddr (gen_req.waddr),
      .wdata (gen_req.wdata),
      .wmask (gen_req.wmask)
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= T_BUILD;
      fill      <= '0;
      bits      <= '0;
      need01    <= 1'b0;
      lenpushed <= 1'b0;
      pad       <= 1'b0;
      oidx      <= '0;
    end else begin
      case (st)
        T_BUILD: if (gen_done) st <= T_CLR;
        T_CLR:   st <= T_IDLE;
        T_IDLE: begin
          if (data_valid) begin
            fill <= fill + 3'd1;
            if (last) begin
              bits      <= bits + {57'd0, bcs, 3'b000};
              need01    <= (bcs == 4'd8);
              lenpushed <= 1'b0;
              pad       <= 1'b1;
              st        <= (fill == 3'd7) ? T_WAIT : T_PAD;
            end else begin
              bits <= bits + 64'd64;
              pad  <= 1'b0;
              if (fill == 3'd7) st <= T_WAIT;
            end
          end
        end
        T_PAD: begin
          fill <= fill + 3'd1;
          if (need01) need01 <= 1'b0;
          else if (fill == 3'd7) lenpushed <= 1'b1;
          if (fill == 3'd7) st <= T_WAIT;
        end
        T_WAIT: begin
          if (core_done) begin
            if (lenpushed) begin
              oidx <= '0;
              st   <= T_OUT;
            end else if (pad) begin
              st <= T_PAD;
            end else begin
              st <= T_IDLE;
            end
          end
        end
        T_OUT: begin
          if (digest_ready) begin
            if (oidx == 2'd2) begin
              oidx      <= '0;
              fill      <= '0;
              bits      <= '0;
              pad       <= 1'b0;
              lenpushed <= 1'b0;
              st        <= T_IDLE;
            end else begin
              oidx <= oidx + 2'd1;
            end
          end
        end
        default: st <= T_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/tgr_sbox.sv
module tgr_sbox (
  input  logic             clk,
  input  logic [1:0][7:0]  raddr,
  output logic [1:0][63:0] rdata,
  input  logic             we,
  input  logic [7:0]       waddr,
  input  logic [63:0]      wdata,
  input  logic [7:0]       wmask
);

  logic [63:0] mem [256];

  always_ff @(posedge clk) begin
    rdata[0] <= mem[raddr[0]];
    rdata[1] <= mem[raddr[1]];
    for (int l = 0; l < 8; l++) begin
      if (we && wmask[l]) begin
        mem[waddr][l*8 +: 8] <= wdata[l*8 +: 8];
      end
    end
  end

endmodule

>>> rtl/tgr_core.sv
module tgr_core (
  input  logic                  clk,
  input  logic                  rst,
  input  tgr_pkg::tgr_core_ctl_t ctl,
  input  logic [3:0][1:0][63:0] sdata,
  output logic [3:0][1:0][7:0]  saddr,
  output logic [2:0][63:0]      cv,
  output logic                  busy,
  output logic                  done
);
  import tgr_pkg::*;

  typedef enum logic [2:0] {C_IDLE, C_RA, C_RB, C_RC, C_SCHED, C_FF} state_t;

  state_t           state;
  logic [7:0][63:0] x;
  logic [2:0][63:0] r;
  logic [2:0]       rnd;
  logic [1:0]       pass;
  logic [3:0]       sstep;

  logic [63:0] v, lo, hi, mulv, tw, sres;

  always_comb begin
    v = r[2] ^ x[0];
    saddr[0][0] = v[7:0];
    saddr[1][0] = v[23:16];
    saddr[2][0] = v[39:32];
    saddr[3][0] = v[55:48];
    saddr[3][1] = v[15:8];
    saddr[2][1] = v[31:24];
    saddr[1][1] = v[47:40];
    saddr[0][1] = v[63:56];
    lo = sdata[0][0] ^ sdata[1][0] ^ sdata[2][0] ^ sdata[3][0];
    hi = sdata[0][1] ^ sdata[1][1] ^ sdata[2][1] ^ sdata[3][1];
    case (pass)
      2'd0:    mulv = r[1] + (r[1] << 2);
      2'd1:    mulv = (r[1] << 3) - r[1];
      default: mulv = r[1] + (r[1] << 3);
    endcase
    case (sstep) inside
      4'd0:         tw = SCHED_K0;
      4'd15:        tw = SCHED_K1;
      4'd3, 4'd9:   tw = (~x[6]) << 19;
      4'd6, 4'd12:  tw = (~x[6]) >> 23;
      default:      tw = '0;
    endcase
    case (sstep) inside
      4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: sres = x[0] - (x[7] ^ tw);
      4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       sres = x[0] ^ x[7];
      default:                              sres = x[0] + x[7];
    endcase
  end

  assign busy = (state != C_IDLE);
  assign done = (state == C_FF);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      cv    <= {IV2, IV1, IV0};
    end else begin
      case (state)
        C_IDLE: begin
          if (ctl.clear) cv <= {IV2, IV1, IV0};
          if (ctl.load) x <= {ctl.word, x[7:1]};
          if (ctl.start) begin
            r     <= cv;
            rnd   <= '0;
            pass  <= '0;
            state <= C_RA;
          end
        end
        C_RA: begin
          r[2]  <= v;
          state <= C_RB;
        end
        C_RB: begin
          r[0]  <= r[0] - lo;
          r[1]  <= r[1] + hi;
          state <= C_RC;
        end
        C_RC: begin
          r   <= {r[0], r[2], mulv};
          x   <= {x[0], x[7:1]};
          rnd <= rnd + 3'd1;
          if (rnd == 3'd7) begin
            if (pass == 2'd2) begin
              state <= C_FF;
            end else begin
              sstep <= '0;
              state <= C_SCHED;
            end
          end else begin
            state <= C_RA;
          end
        end
        C_SCHED: begin
          x     <= {sres, x[7:1]};
          sstep <= sstep + 4'd1;
          if (sstep == 4'd15) begin
            pass  <= pass + 2'd1;
            state <= C_RA;
          end
        end
        C_FF: begin
          cv[0] <= r[0] ^ cv[0];
          cv[1] <= r[1] - cv[1];
          cv[2] <= r[2] + cv[2];
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/tgr_sgen.sv
module tgr_sgen (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [3:0][1:0][63:0]  sdata,
  input  logic [2:0][63:0]       cv,
  input  logic                   core_done,
  output tgr_pkg::tgr_mem_req_t  req,
  output tgr_pkg::tgr_core_ctl_t ctl,
  output logic                   done
);
  import tgr_pkg::*;

  typedef enum logic [2:0] {G_INIT, G_NEXT, G_LOAD, G_RUN, G_RD, G_COL, G_WR, G_DONE} state_t;

  state_t      st;
  logic [7:0]  n;
  logic [1:0]  sb;
  logic [2:0]  cnt;
  logic [1:0]  abc;
  logic [2:0]  lcnt;
  logic [2:0]  col;
  logic [63:0] row;

  logic [63:0] key, rd0, rd1, cur, newrow;
  logic [7:0]  jcur, jnext, p, q;
  logic [2:0]  cnx;
  logic [5:0]  sh;

  always_comb begin
    case (abc)
      2'd0:    key = cv[0];
      2'd1:    key = cv[1];
      default: key = cv[2];
    endcase
    cnx    = col + 3'd1;
    sh     = {col, 3'b000};
    jcur   = key[sh +: 8];
    jnext  = key[{cnx, 3'b000} +: 8];
    rd0    = sdata[sb][0];
    rd1    = sdata[sb][1];
    cur    = (col == 3'd0) ? rd0 : row;
    p      = cur[sh +: 8];
    q      = rd1[sh +: 8];
    newrow = (cur & ~(64'hFF << sh)) | ({56'b0, q} << sh);

    req        = '0;
    req.raddr0 = n;
    req.raddr1 = (st == G_RD) ? jcur : jnext;
    case (st)
      G_INIT: begin
        req.we    = 4'hF;
        req.waddr = n;
        req.wdata = {8{n}};
        req.wmask = 8'hFF;
      end
      G_COL: begin
        req.we    = 4'b0001 << sb;
        req.waddr = jcur;
        req.wdata = {8{p}};
        req.wmask = 8'b0000_0001 << col;
      end
      G_WR: begin
        req.we    = 4'b0001 << sb;
        req.waddr = n;
        req.wdata = row;
        req.wmask = 8'hFF;
      end
      default: ;
    endcase

    ctl       = '0;
    ctl.load  = (st == G_LOAD);
    ctl.word  = SEED[lcnt];
    ctl.start = (st == G_LOAD) && (lcnt == 3'd7);
  end

  assign done = (st == G_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= G_INIT;
      n   <= '0;
      sb  <= '0;
      cnt <= '0;
      abc <= 2'd2;
      col <= '0;
    end else begin
      case (st)
        G_INIT: begin
          n <= n + 8'd1;
          if (n == 8'd255) st <= G_NEXT;
        end
        G_NEXT: begin
          if (abc == 2'd2) begin
            abc  <= '0;
            lcnt <= '0;
            st   <= G_LOAD;
          end else begin
            abc <= abc + 2'd1;
            st  <= G_RD;
          end
        end
        G_LOAD: begin
          lcnt <= lcnt + 3'd1;
          if (lcnt == 3'd7) st <= G_RUN;
        end
        G_RUN: begin
          if (core_done) st <= G_RD;
        end
        G_RD: begin
          col <= '0;
          st  <= G_COL;
        end
        G_COL: begin
          row <= newrow;
          col <= cnx;
          if (col == 3'd7) st <= G_WR;
        end
        G_WR: begin
          sb <= sb + 2'd1;
          if (sb == 2'd3 && n == 8'd255 && cnt == 3'd4) st <= G_DONE;
          else st <= G_NEXT;
          if (sb == 2'd3) begin
            n <= n + 8'd1;
            if (n == 8'd255 && cnt != 3'd4) cnt <= cnt + 3'd1;
          end
        end
        G_DONE: ;
        default: st <= G_DONE;
      endcase
    end
  end

endmodule

>>> tb/tiger192_hash_test.sv
module tiger192_hash_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tgr_pkg::*;

  class digest_scoreboard;
    logic [63:0] sbox [1024];
    logic [63:0] hs [3];
    logic [63:0] r [3];
    logic [63:0] x [8];
    logic [63:0] store [8];
    int unsigned fill;
    logic [63:0] msg_bits;
    logic [64:0] pending [$];
    int errors;

    function new();
      errors = 0;
      build_sboxes();
      restart();
    endfunction

    function void restart();
      hs[0] = IV0;
      hs[1] = IV1;
      hs[2] = IV2;
      fill = 0;
      msg_bits = '0;
    endfunction

    function void tround(int ia, int ib, int ic, logic [63:0] w, logic [63:0] mul);
      logic [63:0] v;
      v = r[ic] ^ w;
      r[ic] = v;
      r[ia] = r[ia] - (sbox[v[7:0]] ^ sbox[256 + v[23:16]] ^ sbox[512 + v[39:32]]
                       ^ sbox[768 + v[55:48]]);
      r[ib] = r[ib] + (sbox[768 + v[15:8]] ^ sbox[512 + v[31:24]] ^ sbox[256 + v[47:40]]
                       ^ sbox[v[63:56]]);
      r[ib] = r[ib] * mul;
    endfunction

    function void tpass(int p0, int p1, int p2, logic [63:0] mul);
      int p [3];
      p[0] = p0;
      p[1] = p1;
      p[2] = p2;
      for (int i = 0; i < 8; i++)
        tround(p[i % 3], p[(i + 1) % 3], p[(i + 2) % 3], x[i], mul);
    endfunction

    function void mix_words();
      x[0] = x[0] - (x[7] ^ SCHED_K0);
      x[1] = x[1] ^ x[0];
      x[2] = x[2] + x[1];
      x[3] = x[3] - (x[2] ^ ((~x[1]) << 19));
      x[4] = x[4] ^ x[3];
      x[5] = x[5] + x[4];
      x[6] = x[6] - (x[5] ^ ((~x[4]) >> 23));
      x[7] = x[7] ^ x[6];
      x[0] = x[0] + x[7];
      x[1] = x[1] - (x[0] ^ ((~x[7]) << 19));
      x[2] = x[2] ^ x[1];
      x[3] = x[3] + x[2];
      x[4] = x[4] - (x[3] ^ ((~x[2]) >> 23));
      x[5] = x[5] ^ x[4];
      x[6] = x[6] + x[5];
      x[7] = x[7] - (x[6] ^ SCHED_K1);
    endfunction

    function void compress(logic [63:0] blk [8]);
      for (int i = 0; i < 8; i++) x[i] = blk[i];
      for (int i = 0; i < 3; i++) r[i] = hs[i];
      tpass(0, 1, 2, 64'd5);
      mix_words();
      tpass(2, 0, 1, 64'd7);
      mix_words();
      tpass(1, 2, 0, 64'd9);
      hs[0] = r[0] ^ hs[0];
      hs[1] = r[1] - hs[1];
      hs[2] = r[2] + hs[2];
    endfunction

    function void build_sboxes();
      logic [63:0] seed_blk [8];
      logic [63:0] m, p, q;
      int abc, j;
      abc = 2;
      restart();
      for (int i = 0; i < 8; i++) seed_blk[i] = SEED[i];
      for (int i = 0; i < 1024; i++) sbox[i] = (i & 255) * 64'h0101010101010101;
      for (int cnt = 0; cnt < 5; cnt++)
        for (int i = 0; i < 256; i++)
          for (int sb = 0; sb < 1024; sb += 256) begin
            abc++;
            if (abc == 3) begin
              abc = 0;
              compress(seed_blk);
            end
            for (int col = 0; col < 8; col++) begin
              j = sb + int'(hs[abc][8 * col +: 8]);
              m = 64'hFF << (8 * col);
              p = sbox[sb + i] & m;
              q = sbox[j] & m;
              sbox[sb + i] = (sbox[sb + i] & ~m) | q;
              sbox[j] = (sbox[j] & ~m) | p;
            end
          end
    endfunction

    function void push_word(logic [63:0] w);
      store[fill] = w;
      fill++;
      if (fill == 8) begin
        compress(store);
        fill = 0;
      end
    endfunction

    function void note_input(logic [63:0] d, logic [3:0] bc_in, logic lst);
      int bc;
      logic [63:0] mask;
      bc = (bc_in > 8) ? 8 : bc_in;
      if (!lst) begin
        msg_bits += 64;
        push_word(d);
        return;
      end
      msg_bits += 64'(bc * 8);
      if (bc == 8) begin
        push_word(d);
        push_word(PAD_WORD);
      end else begin
        mask = (bc == 0) ? 64'd0 : (~64'd0 >> (64 - 8 * bc));
        push_word((d & mask) | (PAD_WORD << (8 * bc)));
      end
      while (fill < 7) push_word('0);
      push_word(msg_bits);
      for (int k = 0; k < 3; k++) pending.push_back({k == 2, hs[k]});
      restart();
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_digest(logic [63:0] w, logic l);
      logic [64:0] e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected digest word %h", w));
        return;
      end
      e = pending.pop_front();
      if (w !== e[63:0]) report($sformatf("digest_word %h, want %h", w, e[63:0]));
      if (l !== e[64]) report($sformatf("digest_last %b, want %b", l, e[64]));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        data_valid;
  logic        data_ready;
  logic [63:0] data;
  logic [3:0]  byte_count;
  logic        last;
  logic        digest_valid;
  logic        digest_ready;
  logic [63:0] digest_word;
  logic        digest_last;

  digest_scoreboard sb;
  int items_sent;
  int digests_seen;
  bit burst;

  tiger192_hash uut (
    .clk(clk),
    .rst(rst),
    .data_valid(data_valid),
    .data_ready(data_ready),
    .data(data),
    .byte_count(byte_count),
    .last(last),
    .digest_valid(digest_valid),
    .digest_ready(digest_ready),
    .digest_word(digest_word),
    .digest_last(digest_last)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  task send_item(logic [63:0] d, logic [3:0] bc, logic lst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      data_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    data_valid <= 1;
    data <= d;
    byte_count <= bc;
    last <= lst;
    do @(posedge clk); while (!data_ready);
    sb.note_input(d, bc, lst);
    items_sent++;
  endtask

  task send_message(int nwords, logic [3:0] last_bc, logic [63:0] last_data);
    burst = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < nwords; i++)
      send_item({$urandom, $urandom}, 4'($urandom_range(0, 15)), 1'b0);
    send_item(last_data, last_bc, 1'b1);
  endtask

  initial begin
    sb = new();
    items_sent = 0;
    rst <= 1;
    data_valid <= 0;
    data <= '0;
    byte_count <= '0;
    last <= 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    send_message(0, 4'd0, '1);
    send_message(0, 4'd1, '1);
    send_message(0, 4'd4, '0);
    send_message(0, 4'd7, '1);
    send_message(0, 4'd8, '1);
    send_message(0, 4'd15, '1);
    send_message(7, 4'd3, '1);
    send_message(6, 4'd8, '0);
    while (items_sent < 300) begin
      if ($urandom_range(0, 4) == 0)
        send_message($urandom_range(0, 3), 4'($urandom_range(0, 15)), {$urandom, $urandom});
      else
        send_message($urandom_range(0, 20), 4'($urandom_range(0, 15)), {$urandom, $urandom});
    end
    data_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    int stall;
    digests_seen = 0;
    digest_ready <= 0;
    @(negedge rst);
    forever begin
      stall = (digests_seen == 6) ? 2000 : $urandom_range(0, 4);
      if (stall > 0) begin
        digest_ready <= 0;
        repeat (stall) @(posedge clk);
      end
      digest_ready <= 1;
      do @(posedge clk); while (!digest_valid);
      sb.check_digest(digest_word, digest_last);
      digests_seen++;
    end
  end

  initial begin
    #24ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

>>> sim.f
rtl/tgr_pkg.sv
rtl/tgr_sbox.sv
rtl/tgr_core.sv
rtl/tgr_sgen.sv
rtl/tiger192_hash.sv
tb/tiger192_hash_test.sv
